### rtl/swir_pkg.sv
// Package for the sorted window store: transfer types, op and status codes,
// controller/datapath command and status structs. No dependencies.
package swir_pkg;

   localparam int DEPTH_DEF       = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_REPLACE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   // scan index update
   localparam logic [2:0] IDX_HOLD = 3'd0;
   localparam logic [2:0] IDX_ZERO = 3'd1;
   localparam logic [2:0] IDX_TOP  = 3'd2;
   localparam logic [2:0] IDX_INC  = 3'd3;
   localparam logic [2:0] IDX_DEC  = 3'd4;
   localparam logic [2:0] IDX_RIDX = 3'd5;

   // write address select
   localparam logic [1:0] WA_IDX_P1 = 2'd0;
   localparam logic [1:0] WA_IDX_M1 = 2'd1;
   localparam logic [1:0] WA_ZERO   = 2'd2;

   // rank select
   localparam logic [1:0] RK_IDX    = 2'd0;
   localparam logic [1:0] RK_IDX_P1 = 2'd1;
   localparam logic [1:0] RK_IDX_M1 = 2'd2;
   localparam logic [1:0] RK_FILL   = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] new_value;
      logic signed [31:0] old_value;
      logic [5:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         new_rank;
      logic signed [31:0] read_value;
      logic [6:0]         fill_count;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic [2:0] idx_op;
      logic       rd_en;
      logic       wr_en;
      logic [1:0] wa_sel;
      logic       wd_nv;
      logic       rank_en;
      logic [1:0] rank_sel;
      logic       fill_inc;
      logic       status_en;
      logic [1:0] status_code;
      logic       rval_en;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       idx_at_fill;
      logic       idx_zero;
      logic       ridx_oor;
      logic       nv_eq_ov;
      logic       nv_lt_ov;
      logic       rd_ge_x;
      logic       rd_ge_nv;
      logic       rd_eq_ov;
      logic       rd_le_nv;
      logic       rsp_free;
   } stat_type;

endpackage

### rtl/swir_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module swir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/swir_ctrl.sv
// Controller state machine for the sorted window store.
// Depends on swir_pkg for the command and status structs.
module swir_ctrl
   import swir_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_FIND_RD  = 4'd2;
   localparam logic [3:0] S_FIND_CK  = 4'd3;
   localparam logic [3:0] S_DN_RD    = 4'd4;
   localparam logic [3:0] S_DN_CK    = 4'd5;
   localparam logic [3:0] S_PUT0     = 4'd6;
   localparam logic [3:0] S_UP_RD    = 4'd7;
   localparam logic [3:0] S_UP_CK    = 4'd8;
   localparam logic [3:0] S_GET_RD   = 4'd9;
   localparam logic [3:0] S_GET_CK   = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       is_insert;

   assign is_insert = (stat.op == OP_INSERT);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (stat.op)
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.status_en   = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else if (stat.empty) begin
                     cmd.wr_en    = 1'b1;
                     cmd.wa_sel   = WA_ZERO;
                     cmd.wd_nv    = 1'b1;
                     cmd.fill_inc = 1'b1;
                  end else begin
                     cmd.idx_op = IDX_TOP;
                     state_in   = S_DN_RD;
                  end
               end
               OP_REPLACE: begin
                  cmd.idx_op = IDX_ZERO;
                  state_in   = S_FIND_RD;
               end
               OP_READ: begin
                  if (stat.ridx_oor) begin
                     cmd.status_en   = 1'b1;
                     cmd.status_code = ST_RANGE;
                  end else begin
                     cmd.idx_op = IDX_RIDX;
                     state_in   = S_GET_RD;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FIND_RD: begin
            if (stat.idx_at_fill) begin
               state_in = S_DONE;
               if (stat.nv_eq_ov) begin
                  cmd.rank_en  = 1'b1;
                  cmd.rank_sel = RK_FILL;
               end else begin
                  cmd.status_en   = 1'b1;
                  cmd.status_code = ST_MISSING;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_FIND_CK;
            end
         end
         S_FIND_CK: begin
            if (!stat.rd_ge_x) begin
               cmd.idx_op = IDX_INC;
               state_in   = S_FIND_RD;
            end else if (stat.nv_eq_ov) begin
               cmd.rank_en  = 1'b1;
               cmd.rank_sel = RK_IDX;
               state_in     = S_DONE;
            end else if (!stat.rd_eq_ov) begin
               cmd.status_en   = 1'b1;
               cmd.status_code = ST_MISSING;
               state_in        = S_DONE;
            end else if (stat.nv_lt_ov) begin
               if (stat.idx_zero) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wa_sel = WA_ZERO;
                  cmd.wd_nv  = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  cmd.idx_op = IDX_DEC;
                  state_in   = S_DN_RD;
               end
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_UP_RD;
            end
         end
         S_DN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DN_CK;
         end
         S_DN_CK: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX_P1;
            if (stat.rd_ge_nv) begin
               // shift the entry up one slot
               if (stat.idx_zero) begin
                  state_in = S_PUT0;
               end else begin
                  cmd.idx_op = IDX_DEC;
                  state_in   = S_DN_RD;
               end
            end else begin
               cmd.wd_nv    = 1'b1;
               cmd.rank_en  = 1'b1;
               cmd.rank_sel = RK_IDX_P1;
               cmd.fill_inc = is_insert;
               state_in     = S_DONE;
            end
         end
         S_PUT0: begin
            cmd.wr_en    = 1'b1;
            cmd.wa_sel   = WA_ZERO;
            cmd.wd_nv    = 1'b1;
            cmd.fill_inc = is_insert;
            state_in     = S_DONE;
         end
         S_UP_RD: begin
            if (stat.idx_at_fill) begin
               cmd.wr_en    = 1'b1;
               cmd.wa_sel   = WA_IDX_M1;
               cmd.wd_nv    = 1'b1;
               cmd.rank_en  = 1'b1;
               cmd.rank_sel = RK_IDX_M1;
               state_in     = S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_UP_CK;
            end
         end
         S_UP_CK: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX_M1;
            if (stat.rd_le_nv) begin
               cmd.idx_op = IDX_INC;
               state_in   = S_UP_RD;
            end else begin
               cmd.wd_nv    = 1'b1;
               cmd.rank_en  = 1'b1;
               cmd.rank_sel = RK_IDX_M1;
               state_in     = S_DONE;
            end
         end
         S_GET_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_GET_CK;
         end
         S_GET_CK: begin
            cmd.rval_en = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### rtl/swir_dp.sv
// Datapath of the sorted window store: item registers, scan index, fill
// level, result register and the value RAM. Depends on swir_pkg, swir_ram.
module swir_dp
   import swir_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req,
   input  cmd_type  cmd,
   output stat_type stat,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int RW = CW + 6;

   logic [1:0]                    op_ff;
   logic signed [VALUE_WIDTH-1:0] nv_ff, ov_ff;
   logic [5:0]                    ridx_ff;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [CW-1:0]                 fill_ff;
   logic [CW-1:0]                 rank_ff;
   logic [1:0]                    status_ff;
   logic signed [VALUE_WIDTH-1:0] rval_ff;
   rsp_type                       rsp_ff;
   logic                          rsp_valid_ff;

   logic [VALUE_WIDTH-1:0]        rd_raw;
   logic signed [VALUE_WIDTH-1:0] rd_val, key, wr_data;
   logic [CW-1:0]                 idx_p1, idx_m1, wr_idx;
   logic [AW-1:0]                 wr_addr;

   assign rd_val  = $signed(rd_raw);
   assign key     = (nv_ff == ov_ff) ? nv_ff : ov_ff;
   assign idx_p1  = idx_ff + 1'b1;
   assign idx_m1  = idx_ff - 1'b1;
   assign wr_data = cmd.wd_nv ? nv_ff : rd_val;

   always_comb begin
      case (cmd.wa_sel)
         WA_IDX_P1: wr_idx = idx_p1;
         WA_IDX_M1: wr_idx = idx_m1;
         default:   wr_idx = '0;
      endcase
   end
   assign wr_addr = wr_idx[AW-1:0];

   always_comb begin
      case (cmd.idx_op)
         IDX_ZERO: idx_in = '0;
         IDX_TOP:  idx_in = fill_ff - 1'b1;
         IDX_INC:  idx_in = idx_p1;
         IDX_DEC:  idx_in = idx_m1;
         IDX_RIDX: idx_in = CW'(ridx_ff);
         default:  idx_in = idx_ff;
      endcase
   end

   swir_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req.op;
         nv_ff     <= VALUE_WIDTH'(req.new_value);
         ov_ff     <= VALUE_WIDTH'(req.old_value);
         ridx_ff   <= req.read_index;
         rank_ff   <= '0;
         status_ff <= ST_OK;
         rval_ff   <= '0;
      end else begin
         if (cmd.status_en) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.rval_en) begin
            rval_ff <= rd_val;
         end
         if (cmd.rank_en) begin
            case (cmd.rank_sel)
               RK_IDX:    rank_ff <= idx_ff;
               RK_IDX_P1: rank_ff <= idx_p1;
               RK_IDX_M1: rank_ff <= idx_m1;
               default:   rank_ff <= fill_ff;
            endcase
         end
      end
      idx_ff <= idx_in;
      if (cmd.rsp_load) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.new_rank   <= 7'(rank_ff);
         rsp_ff.read_value <= 32'(rval_ff);
         rsp_ff.fill_count <= 7'(fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.fill_inc) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.op          = op_ff;
   assign stat.full        = (fill_ff == CW'(DEPTH));
   assign stat.empty       = (fill_ff == '0);
   assign stat.idx_at_fill = (idx_ff >= fill_ff);
   assign stat.idx_zero    = (idx_ff == '0);
   assign stat.ridx_oor    = (RW'(ridx_ff) >= RW'(fill_ff));
   assign stat.nv_eq_ov    = (nv_ff == ov_ff);
   assign stat.nv_lt_ov    = (nv_ff < ov_ff);
   assign stat.rd_ge_x     = (rd_val >= key);
   assign stat.rd_ge_nv    = (rd_val >= nv_ff);
   assign stat.rd_eq_ov    = (rd_val == ov_ff);
   assign stat.rd_le_nv    = (rd_val <= nv_ff);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill level above depth");
   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_inc |-> (fill_ff < CW'(DEPTH)))
      else $error("insert into full store");
   a_write_in_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (wr_idx <= fill_ff))
      else $error("write beyond held values");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_inc |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("fill level did not advance");
endmodule

### rtl/sorted_window_insert_replace.sv
// Top level of the sorted window store: joins controller and datapath.
// Depends on swir_pkg, swir_ctrl, swir_dp (and swir_ram below it).
//
// Usage: keeps up to DEPTH signed values in ascending order for a sliding
// window quantile. Each request transfer (req_valid/req_ready, payload
// req of req_type) carries an op: insert, replace old by new, or read at a
// rank. Each request gives exactly one response transfer (rsp_valid /
// rsp_ready, payload rsp of rsp_type) with status, rank of the new value,
// read value and the fill count after the item.
// Flow: one item at a time. The RAM scan visits each entry with a read,
// then a compare and, while moving entries, a write. Insert visits the
// entries above the new rank, replace visits entries from rank 0 up to
// the old value and then over the span it moves across; a read visits
// a single entry.
// Reset clears the fill level and the response valid; stored values stay
// undefined until written and are never read before that.
// If the receiver stalls, the response holds in its output register; one
// more request is taken and worked, then waits until the register frees.
module sorted_window_insert_replace
   import swir_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);
   cmd_type  cmd;
   stat_type stat;

   // sequence the scan steps
   swir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the values, index and result register
   swir_dp #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   a_load_on_transfer: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && req_ready))
      else $error("item captured without transfer");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || rsp_ready))
      else $error("pending response overwritten");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid)
      else $error("response not presented");
endmodule
